>>> design/owtsr_pkg.sv
// Package for the one-wire temperature sensor reader.
// Holds phase codes, register indexes, status codes, reset values and the CRC-8 step.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package owtsr_pkg;

  // Scratchpad bytes read from the sensor, the last one is the CRC
  localparam int unsigned SCRATCH_BYTES = 9;

  localparam int unsigned TICK_W = 20;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned OUT_W  = 48;

  // Command bytes: skip-ROM, convert, skip-ROM, read-scratchpad
  localparam logic [7:0] CMD_SEQ [4] = '{8'hCC, 8'h44, 8'hCC, 8'hBE};

  // Reset values of the timing registers (microsecond ticks)
  localparam logic [9:0]  RESET_LOW_RST    = 10'd480;
  localparam logic [9:0]  PRES_TIMEOUT_RST = 10'd100;
  localparam logic [9:0]  PEND_TIMEOUT_RST = 10'd300;
  localparam logic [19:0] CONVERT_WAIT_RST = 20'd1000000;
  localparam logic [5:0]  SLOT_START_RST   = 6'd2;
  localparam logic [6:0]  SLOT_LONG_RST    = 7'd60;
  localparam logic [5:0]  SAMPLE_DELAY_RST = 6'd15;
  localparam logic [6:0]  READ_TAIL_RST    = 7'd50;

  typedef enum logic [2:0] {
    CFG_RESET_LOW    = 3'd0,
    CFG_PRES_TIMEOUT = 3'd1,
    CFG_PEND_TIMEOUT = 3'd2,
    CFG_CONVERT_WAIT = 3'd3,
    CFG_SLOT_START   = 3'd4,
    CFG_SLOT_LONG    = 3'd5,
    CFG_SAMPLE_DELAY = 3'd6,
    CFG_READ_TAIL    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_PRES  = 2'd1,
    STATUS_STUCK    = 2'd2,
    STATUS_CRC_FAIL = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    PH_IDLE = 10'b00_0000_0001,
    PH_RST  = 10'b00_0000_0010,
    PH_PRES = 10'b00_0000_0100,
    PH_PEND = 10'b00_0000_1000,
    PH_TXL  = 10'b00_0001_0000,
    PH_TXH  = 10'b00_0010_0000,
    PH_CONV = 10'b00_0100_0000,
    PH_RXL  = 10'b00_1000_0000,
    PH_RXW  = 10'b01_0000_0000,
    PH_RXT  = 10'b10_0000_0000
  } phase_e;

  // Timing register set
  typedef struct packed {
    logic [9:0]  reset_low;
    logic [9:0]  pres_timeout;
    logic [9:0]  pend_timeout;
    logic [19:0] convert_wait;
    logic [5:0]  slot_start;
    logic [6:0]  slot_long;
    logic [5:0]  sample_delay;
    logic [6:0]  read_tail;
  } cfg_t;

  // Converted temperature fields
  typedef struct packed {
    logic        negative;
    logic [11:0] whole;
    logic [6:0]  hundredths;
  } temp_fields_t;

  // One byte through the reflected CRC-8 (polynomial 0x8C)
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/one_wire_temp_sensor_reader_unit.sv
// Top level of the one-wire temperature sensor reader.
// Depends on owtsr_pkg and owtsr_temp_conv.
`timescale 1ns / 1ps

// Usage:
//   Feed one microsecond tick per transfer on the s_axis channel: tdata[0] is the
//   sampled bus level, tuser[0] set on a tick starts a measurement while idle.
//   Every tick gives exactly one result on the m_axis channel: drive_low for the
//   bus driver, busy, done and the last status, and on a finishing tick with
//   status ok the raw temperature, its sign, whole degrees and hundredths.
//   A measurement runs reset, presence, skip-ROM/convert, the conversion wait,
//   a second reset, skip-ROM/read-scratchpad and nine read bytes with CRC check.
//   An input transfer's result is in the output register on the next clock; one
//   tick is taken every cycle unless the receiver stalls, since each tick's update
//   is one pass through the phase logic between the state and output registers.
//   When the receiver stalls, the result holds and s_axis_tready drops only while
//   the full output register is not being taken.
//   Reset puts the block idle with status ok and the timing registers at their
//   defaults; timing registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i.

module one_wire_temp_sensor_reader_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input ticks
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [0] line_level, [7:1] zero
  input  logic [0:0]                  s_axis_tuser,   // [0] cmd
  // Results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [20:5] temp_raw,
  // [21] temp_negative, [33:22] temp_whole, [40:34] temp_hundredths, [47:41] zero
  output logic [owtsr_pkg::OUT_W-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_addr_i,
  input  logic [owtsr_pkg::CFG_W-1:0] cfg_wdata_i
);
  import owtsr_pkg::*;

  cfg_t        cfg_q;
  phase_e      phase_q, phase_d, ph;
  logic [19:0] tick_q, tick_d, tick_e, tick_inc, limit;
  logic [2:0]  bit_q, bit_d, bit_e, bit_inc;
  logic [3:0]  byte_q, byte_d, byte_e, byte_inc, n_idx;
  logic [4:0]  n_next;
  logic [7:0]  shift_q, shift_d, shift_e;
  logic [7:0]  crc_q, crc_d, crc_e;
  logic [1:0]  status_q, status_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d;
  logic        start, bitv, hit, drv, done;
  logic [15:0] raw;
  temp_fields_t fields;

  logic                in_fire;
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_data_q, out_data_d;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low    <= RESET_LOW_RST;
      cfg_q.pres_timeout <= PRES_TIMEOUT_RST;
      cfg_q.pend_timeout <= PEND_TIMEOUT_RST;
      cfg_q.convert_wait <= CONVERT_WAIT_RST;
      cfg_q.slot_start   <= SLOT_START_RST;
      cfg_q.slot_long    <= SLOT_LONG_RST;
      cfg_q.sample_delay <= SAMPLE_DELAY_RST;
      cfg_q.read_tail    <= READ_TAIL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_RESET_LOW:    cfg_q.reset_low    <= cfg_wdata_i[9:0];
        CFG_PRES_TIMEOUT: cfg_q.pres_timeout <= cfg_wdata_i[9:0];
        CFG_PEND_TIMEOUT: cfg_q.pend_timeout <= cfg_wdata_i[9:0];
        CFG_CONVERT_WAIT: cfg_q.convert_wait <= cfg_wdata_i[19:0];
        CFG_SLOT_START:   cfg_q.slot_start   <= cfg_wdata_i[5:0];
        CFG_SLOT_LONG:    cfg_q.slot_long    <= cfg_wdata_i[6:0];
        CFG_SAMPLE_DELAY: cfg_q.sample_delay <= cfg_wdata_i[5:0];
        CFG_READ_TAIL:    cfg_q.read_tail    <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Apply a start, pick the running limit and advance the phase
  always_comb begin
    start   = (phase_q == PH_IDLE) && s_axis_tuser[0];
    ph      = start ? PH_RST : phase_q;
    tick_e  = start ? '0 : tick_q;
    bit_e   = start ? '0 : bit_q;
    byte_e  = start ? '0 : byte_q;
    shift_e = start ? '0 : shift_q;
    crc_e   = start ? '0 : crc_q;

    bitv = CMD_SEQ[byte_e[1:0]][bit_e];

    unique case (ph)
      PH_RST:  limit = {10'd0, cfg_q.reset_low};
      PH_PRES: limit = {10'd0, cfg_q.pres_timeout};
      PH_PEND: limit = {10'd0, cfg_q.pend_timeout};
      PH_TXL:  limit = bitv ? {14'd0, cfg_q.slot_start} : {13'd0, cfg_q.slot_long};
      PH_TXH:  limit = bitv ? {13'd0, cfg_q.slot_long} : {14'd0, cfg_q.slot_start};
      PH_CONV: limit = cfg_q.convert_wait;
      PH_RXL:  limit = {14'd0, cfg_q.slot_start};
      PH_RXW:  limit = {14'd0, cfg_q.sample_delay};
      PH_RXT:  limit = {13'd0, cfg_q.read_tail};
      default: limit = '0;
    endcase

    tick_inc = tick_e + 20'd1;
    hit      = tick_inc >= limit;
    bit_inc  = bit_e + 3'd1;
    byte_inc = byte_e + 4'd1;
    n_idx    = (byte_e >= 4'(SCRATCH_BYTES - 1)) ? 4'(SCRATCH_BYTES - 1) : byte_e;
    n_next   = {1'b0, n_idx} + 5'd1;

    phase_d  = ph;
    tick_d   = tick_e;
    bit_d    = bit_e;
    byte_d   = byte_e;
    shift_d  = shift_e;
    crc_d    = crc_e;
    status_d = status_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    drv      = 1'b0;
    done     = 1'b0;

    unique case (ph)
      PH_IDLE: ;
      PH_RST: begin
        drv    = 1'b1;
        tick_d = hit ? '0 : tick_inc;
        if (hit) phase_d = PH_PRES;
      end
      PH_PRES: begin
        if (!s_axis_tdata[0]) begin
          phase_d = PH_PEND;
          tick_d  = '0;
        end else begin
          tick_d = hit ? '0 : tick_inc;
          if (hit) begin
            status_d = STATUS_NO_PRES;
            done     = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
      end
      PH_PEND: begin
        if (s_axis_tdata[0]) begin
          bit_d   = '0;
          phase_d = PH_TXL;
          tick_d  = '0;
        end else begin
          tick_d = hit ? '0 : tick_inc;
          if (hit) begin
            status_d = STATUS_STUCK;
            done     = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
      end
      PH_TXL: begin
        drv    = 1'b1;
        tick_d = hit ? '0 : tick_inc;
        if (hit) phase_d = PH_TXH;
      end
      PH_TXH: begin
        tick_d = hit ? '0 : tick_inc;
        if (hit) begin
          bit_d = bit_inc;
          if (bit_inc != 3'd0) begin
            phase_d = PH_TXL;
          end else begin
            byte_d = byte_inc;
            if (byte_inc == 4'd2) begin
              phase_d = PH_CONV;
            end else if (byte_inc >= 4'd4) begin
              byte_d  = '0;
              shift_d = '0;
              crc_d   = '0;
              phase_d = PH_RXL;
            end else begin
              phase_d = PH_TXL;
            end
          end
        end
      end
      PH_CONV: begin
        tick_d = hit ? '0 : tick_inc;
        if (hit) phase_d = PH_RST;
      end
      PH_RXL: begin
        drv    = 1'b1;
        tick_d = hit ? '0 : tick_inc;
        if (hit) phase_d = PH_RXW;
      end
      PH_RXW: begin
        tick_d = hit ? '0 : tick_inc;
        if (hit) begin
          if (s_axis_tdata[0]) shift_d = shift_e | (8'd1 << bit_e);
          phase_d = PH_RXT;
        end
      end
      PH_RXT: begin
        tick_d = hit ? '0 : tick_inc;
        if (hit) begin
          bit_d = bit_inc;
          if (bit_inc != 3'd0) begin
            phase_d = PH_RXL;
          end else begin
            // Keep only the two temperature bytes of the scratchpad
            if (n_idx == 4'd0) lo_d = shift_e;
            if (n_idx == 4'd1) hi_d = shift_e;
            if (n_next >= 5'(SCRATCH_BYTES)) begin
              status_d = (crc_e == shift_e) ? STATUS_OK : STATUS_CRC_FAIL;
              done     = 1'b1;
              phase_d  = PH_IDLE;
            end else begin
              crc_d   = crc8_step(crc_e, shift_e);
              byte_d  = n_next[3:0];
              shift_d = '0;
              phase_d = PH_RXL;
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  // Temperature fields, shown only on a finishing tick with status ok
  assign raw = (done && status_d == STATUS_OK) ? {hi_d, lo_d} : 16'd0;

  owtsr_temp_conv u_conv (
    .raw_i    (raw),
    .fields_o (fields)
  );

  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = drv;
    out_data_d[1]     = (phase_d != PH_IDLE);
    out_data_d[2]     = done;
    out_data_d[4:3]   = status_d;
    out_data_d[20:5]  = raw;
    out_data_d[21]    = fields.negative;
    out_data_d[33:22] = fields.whole;
    out_data_d[40:34] = fields.hundredths;
  end

  // Sequencer state, advanced on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      bit_q    <= '0;
      byte_q   <= '0;
      shift_q  <= '0;
      crc_q    <= '0;
      status_q <= STATUS_OK;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      byte_q   <= byte_d;
      shift_q  <= shift_d;
      crc_q    <= crc_d;
      status_q <= status_d;
    end
  end

  // Temperature bytes and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      out_data_q <= out_data_d;
    end
  end

  // Output valid: set on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

>>> design/owtsr_temp_conv.sv
// Temperature converter: raw sixteenths of a degree to sign, whole degrees, hundredths.
// Depends on owtsr_pkg for the result field struct.
`timescale 1ns / 1ps

module owtsr_temp_conv (
  input  logic [15:0]                  raw_i,
  output owtsr_pkg::temp_fields_t      fields_o
);
  import owtsr_pkg::*;

  logic [15:0] mag;
  logic [10:0] frac_prod;

  // Take the magnitude; the most negative code gives 32768
  assign mag = raw_i[15] ? (16'd0 - raw_i) : raw_i;

  // Fraction in hundredths, truncated
  assign frac_prod = {7'd0, mag[3:0]} * 11'd100;

  assign fields_o.negative   = raw_i[15];
  assign fields_o.whole      = mag[15:4];
  assign fields_o.hundredths = frac_prod[10:4];

endmodule

>>> design/owtsr_checker.sv
// Port-level checks for the one-wire temperature sensor reader, with its bind.
// Depends on owtsr_pkg and one_wire_temp_sensor_reader_unit.
`timescale 1ns / 1ps

module owtsr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [owtsr_pkg::OUT_W-1:0] m_axis_tdata
);
  import owtsr_pkg::*;

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Input is refused only while a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without a pending result");

  // A finishing tick is not busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
    else $error("done while busy");

  // Temperature fields are zero unless finished with status ok
  a_temp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (!m_axis_tdata[2] || m_axis_tdata[4:3] != STATUS_OK)
    |-> m_axis_tdata[40:5] == '0)
    else $error("temperature shown outside a good finish");

  // No result leaves reset
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind one_wire_temp_sensor_reader_unit owtsr_checker u_owtsr_checker (.*);
